// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the keyframe vertex interpolator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/kvi_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types of the keyframe vertex interpolator.
package kvi_pkg;

  localparam int unsigned MAX_FRAMES = 1024;

  localparam int TIME_W    = 31;
  localparam int WEIGHT_W  = 16;
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 20;
  localparam int COUNT_W   = 11;
  localparam int FRAME_W   = 10;
  localparam int PERIOD_W  = 16;
  localparam int SCALE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 96;

  // Long division of {time, 16 zero bits} yields quotient and weight at once.
  localparam int DVD_W  = TIME_W + WEIGHT_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam int MUL_W       = 18;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int BLEND_W     = 32;
  localparam int ACC_W       = 49;
  localparam int ROUND_SHIFT = 24;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (ROUND_SHIFT - 1));

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;

  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(100);

  localparam logic [COUNT_W-1:0]  RST_FRAME_COUNT  = COUNT_W'(1);
  localparam logic [FRAME_W-1:0]  RST_START_FRAME  = '0;
  localparam logic [COUNT_W-1:0]  RST_FRAME_RANGE  = COUNT_W'(1);
  localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD = PERIOD_W'(100);
  localparam logic [SCALE_W-1:0]  RST_VERTEX_SCALE = SCALE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT  = 3'd0,
    REG_START_FRAME  = 3'd1,
    REG_FRAME_RANGE  = 3'd2,
    REG_FRAME_PERIOD = 3'd3,
    REG_VERTEX_SCALE = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/kvi_divider.sv =====
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module kvi_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  kvi_pkg::div_req_t             req,
  input  logic [kvi_pkg::DVD_W-1:0]     dividend,
  input  logic [kvi_pkg::PERIOD_W-1:0]  divisor,
  output kvi_pkg::div_stat_t            stat,
  output logic [kvi_pkg::DVD_W-1:0]     quotient,
  output logic [kvi_pkg::PERIOD_W-1:0]  remainder
);
  import kvi_pkg::*;

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   cnt;
  logic [DVD_W-1:0]    dvd;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] dvs;
  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W:0]   diff;
  logic                fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= fits ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;
  assign remainder = rem;

  `ASSERT_NEXT(a_start_sets_busy, clk, rst, req.start, busy)
  `ASSERT_IMPLIES(a_rem_below_divisor, clk, rst, done, rem < dvs)
  `ASSERT_IMPLIES(a_done_follows_busy, clk, rst, done, $past(busy))

endmodule

// ===== hdl/kvi_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module kvi_mul (
  input  logic                               clk,
  input  logic signed [kvi_pkg::MUL_W-1:0]   a,
  input  logic signed [kvi_pkg::MUL_W-1:0]   b,
  output logic signed [kvi_pkg::PROD_W-1:0]  p
);
  import kvi_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hdl/keyframe_vertex_interpolator.sv =====
`timescale 1ns / 1ps
// Keyframe vertex interpolator: one item in, one result out, under a small sequencer.
// A tick runs a 47-step pass of the shared divider, which gives frame quotient and
// weight, then a 31-step pass that wraps the quotient. A vertex takes six sequencer
// steps per axis on one shared multiplier. Input is ready again in the same cycle
// that the result turns valid; a held result stalls.
// Reset is synchronous: registers return to 1, 0, 1, 100, 256 and the stored weight to zero.
`include "assert_macros.svh"
module keyframe_vertex_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream. tdata from bit 0: elapsed_time, first_x, first_y, first_z,
  // second_x, second_y, second_z, one pad bit. tuser: command.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [kvi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,
  // Result stream. tdata from bit 0: frame_a, frame_b, weight, out_x, out_z, out_y.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [kvi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [kvi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kvi_pkg::CFG_W-1:0]        cfg_data
);
  import kvi_pkg::*;

  // Field positions inside the input tdata.
  localparam int FX_LSB = TIME_W;
  localparam int FY_LSB = FX_LSB + COORD_W;
  localparam int FZ_LSB = FY_LSB + COORD_W;
  localparam int SX_LSB = FZ_LSB + COORD_W;
  localparam int SY_LSB = SX_LSB + COORD_W;
  localparam int SZ_LSB = SY_LSB + COORD_W;
  localparam int SH_W   = ACC_W - ROUND_SHIFT;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);
  localparam logic [OUT_W-1:0]  OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_T_COUNT  = 14'b00000000000010,
    ST_T_START  = 14'b00000000000100,
    ST_T_RANGE  = 14'b00000000001000,
    ST_T_DIV1   = 14'b00000000010000,
    ST_T_DIV2   = 14'b00000000100000,
    ST_T_FRAMES = 14'b00000001000000,
    ST_V_DIFF   = 14'b00000010000000,
    ST_V_BLEND  = 14'b00000100000000,
    ST_V_HI     = 14'b00001000000000,
    ST_V_LO     = 14'b00010000000000,
    ST_V_ACC    = 14'b00100000000000,
    ST_V_SAT    = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [COUNT_W-1:0]  frame_count;
  logic [FRAME_W-1:0]  start_frame;
  logic [COUNT_W-1:0]  frame_range;
  logic [PERIOD_W-1:0] frame_period;
  logic [SCALE_W-1:0]  vertex_scale;

  logic [WEIGHT_W-1:0] blend_weight;

  // Latched item.
  cmd_t                      cmd;
  logic [TIME_W-1:0]         t_reg;
  logic signed [COORD_W-1:0] coord_a [NUM_AXES];
  logic signed [COORD_W-1:0] coord_b [NUM_AXES];
  logic [AXIS_W-1:0]         axis;

  // Tick working registers.
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] eff_start;
  logic [COUNT_W-1:0] eff_range;
  logic [COUNT_W-1:0] res_fa;
  logic [COUNT_W-1:0] res_fb;

  // Vertex working registers.
  logic [BLEND_W-1:0] bsum;
  logic [ACC_W-1:0]   acc;
  logic [OUT_W-1:0]   res_xyz [NUM_AXES];

  logic [OUT_DATA_W-1:0] out_data;

  // Shared units.
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DVD_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic [DVD_W-1:0]    div_q;
  logic [PERIOD_W-1:0] div_rem;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // Combinational helpers.
  logic [COUNT_W-1:0]        count_c;
  logic [COUNT_W-1:0]        start_c;
  logic [COUNT_W-1:0]        range_raw;
  logic [COUNT_W:0]          range_sum;
  logic [COUNT_W-1:0]        range_c;
  logic [PERIOD_W-1:0]       period_c;
  logic [COUNT_W-1:0]        fb_inc;
  logic [COUNT_W:0]          loop_end;
  logic [COUNT_W-1:0]        fb_c;
  logic signed [COORD_W-1:0] sel_a;
  logic signed [COORD_W-1:0] sel_b;
  logic [COORD_W:0]          diff_ab;
  logic [PROD_W-1:0]         a_ext;
  logic [PROD_W-1:0]         blend_c;
  logic [ACC_W-1:0]          prod_ext;
  logic [SH_W-1:0]           sh;
  logic [OUT_W-1:0]          sat_c;
  logic                      accept;
  logic                      out_free;
  logic                      div_phase;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tdata  = out_data;

  // States in which the shared divider may be running.
  assign div_phase = state inside {ST_T_START, ST_T_RANGE, ST_T_DIV1, ST_T_DIV2};

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= RST_FRAME_COUNT;
      start_frame  <= RST_START_FRAME;
      frame_range  <= RST_FRAME_RANGE;
      frame_period <= RST_FRAME_PERIOD;
      vertex_scale <= RST_VERTEX_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT:  frame_count  <= cfg_data[COUNT_W-1:0];
        REG_START_FRAME:  start_frame  <= cfg_data[FRAME_W-1:0];
        REG_FRAME_RANGE:  frame_range  <= cfg_data[COUNT_W-1:0];
        REG_FRAME_PERIOD: frame_period <= cfg_data[PERIOD_W-1:0];
        REG_VERTEX_SCALE: vertex_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamping of the loop description. Each step reads the one registered before it,
  // and all of them finish while the first divider pass is still running.
  always_comb begin
    if (frame_count == '0) begin
      count_c = COUNT_W'(1);
    end else if (32'(frame_count) > MAX_FRAMES) begin
      count_c = COUNT_W'(MAX_FRAMES);
    end else begin
      count_c = frame_count;
    end

    start_c = (COUNT_W'(start_frame) >= eff_count) ? eff_count - COUNT_W'(1)
                                                    : COUNT_W'(start_frame);

    range_raw = (frame_range == '0) ? COUNT_W'(1) : frame_range;
    range_sum = {1'b0, eff_start} + {1'b0, range_raw};
    range_c   = (range_sum > {1'b0, eff_count}) ? eff_count - eff_start : range_raw;

    period_c = (frame_period == '0) ? DEFAULT_PERIOD : frame_period;

    // The following frame wraps back to the start at the end of the loop.
    fb_inc   = res_fa + COUNT_W'(1);
    loop_end = {1'b0, eff_start} + {1'b0, eff_range};
    fb_c     = ({1'b0, fb_inc} >= loop_end) ? eff_start : fb_inc;
  end

  // Divider requests: the first pass divides time, with 16 fraction bits appended,
  // by the period; the second pass takes the frame quotient modulo the range.
  always_comb begin
    div_req.start = (state == ST_T_COUNT) || ((state == ST_T_DIV1) && div_stat.done);
    if (state == ST_T_COUNT) begin
      div_req.steps = STEP_W'(DVD_W);
      div_dividend  = {t_reg, {WEIGHT_W{1'b0}}};
      div_divisor   = period_c;
    end else begin
      div_req.steps = STEP_W'(TIME_W);
      div_dividend  = {div_q[DVD_W-1:WEIGHT_W], {WEIGHT_W{1'b0}}};
      div_divisor   = PERIOD_W'(eff_range);
    end
  end

  // Vertex arithmetic. With d = b - a the blend is B = a * 65536 + d * w, which
  // fits 32 bits. B * scale is split into its signed upper and unsigned lower
  // halves so that each product stays on the 18 by 18 multiplier.
  always_comb begin
    sel_a   = coord_a[axis];
    sel_b   = coord_b[axis];
    diff_ab = {sel_b[COORD_W-1], sel_b} - {sel_a[COORD_W-1], sel_a};

    case (state)
      ST_V_DIFF: begin
        mul_a = {diff_ab[COORD_W], diff_ab};
        mul_b = {{(MUL_W-WEIGHT_W){1'b0}}, blend_weight};
      end
      ST_V_HI: begin
        mul_a = {{(MUL_W-WEIGHT_W){bsum[BLEND_W-1]}}, bsum[BLEND_W-1:WEIGHT_W]};
        mul_b = {{(MUL_W-SCALE_W){1'b0}}, vertex_scale};
      end
      default: begin
        mul_a = {{(MUL_W-WEIGHT_W){1'b0}}, bsum[WEIGHT_W-1:0]};
        mul_b = {{(MUL_W-SCALE_W){1'b0}}, vertex_scale};
      end
    endcase

    a_ext    = {{(PROD_W-COORD_W-WEIGHT_W){sel_a[COORD_W-1]}}, sel_a, {WEIGHT_W{1'b0}}};
    blend_c  = a_ext + prod;
    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    // Arithmetic shift right floors, then the result saturates to the field.
    sh = acc[ACC_W-1:ROUND_SHIFT];
    if ((sh[SH_W-1:OUT_W-1] == '0) || (sh[SH_W-1:OUT_W-1] == '1)) begin
      sat_c = sh[OUT_W-1:0];
    end else if (sh[SH_W-1]) begin
      sat_c = OUT_MIN;
    end else begin
      sat_c = OUT_MAX;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd_t'(s_axis_tuser) == CMD_VERTEX) ? ST_V_DIFF : ST_T_COUNT;
        end
      end
      ST_T_COUNT:  state_next = ST_T_START;
      ST_T_START:  state_next = ST_T_RANGE;
      ST_T_RANGE:  state_next = ST_T_DIV1;
      ST_T_DIV1: begin
        if (div_stat.done) begin
          state_next = ST_T_DIV2;
        end
      end
      ST_T_DIV2: begin
        if (div_stat.done) begin
          state_next = ST_T_FRAMES;
        end
      end
      ST_T_FRAMES: state_next = ST_DONE;
      ST_V_DIFF:   state_next = ST_V_BLEND;
      ST_V_BLEND:  state_next = ST_V_HI;
      ST_V_HI:     state_next = ST_V_LO;
      ST_V_LO:     state_next = ST_V_ACC;
      ST_V_ACC:    state_next = ST_V_SAT;
      ST_V_SAT:    state_next = (axis == LAST_AXIS) ? ST_DONE : ST_V_DIFF;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      axis          <= '0;
      blend_weight  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        axis <= '0;
      end else if (state == ST_V_SAT) begin
        axis <= axis + AXIS_W'(1);
      end
      if ((state == ST_T_DIV1) && div_stat.done) begin
        blend_weight <= div_q[WEIGHT_W-1:0];
      end
      if ((state == ST_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers. The coordinate pairs are stored in output order x, z, y.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= cmd_t'(s_axis_tuser);
      t_reg      <= s_axis_tdata[TIME_W-1:0];
      coord_a[0] <= s_axis_tdata[FX_LSB +: COORD_W];
      coord_a[1] <= s_axis_tdata[FZ_LSB +: COORD_W];
      coord_a[2] <= s_axis_tdata[FY_LSB +: COORD_W];
      coord_b[0] <= s_axis_tdata[SX_LSB +: COORD_W];
      coord_b[1] <= s_axis_tdata[SZ_LSB +: COORD_W];
      coord_b[2] <= s_axis_tdata[SY_LSB +: COORD_W];
    end

    case (state)
      ST_T_COUNT:  eff_count <= count_c;
      ST_T_START:  eff_start <= start_c;
      ST_T_RANGE:  eff_range <= range_c;
      ST_T_DIV2: begin
        if (div_stat.done) begin
          res_fa <= eff_start + COUNT_W'(div_rem);
        end
      end
      ST_T_FRAMES: res_fb <= fb_c;
      ST_V_BLEND:  bsum <= blend_c[BLEND_W-1:0];
      ST_V_LO:     acc <= (prod_ext << WEIGHT_W) + ROUND_BIAS;
      ST_V_ACC:    acc <= acc + prod_ext;
      ST_V_SAT:    res_xyz[axis] <= sat_c;
      ST_DONE: begin
        if (out_free) begin
          if (cmd == CMD_VERTEX) begin
            out_data <= {res_xyz[2], res_xyz[1], res_xyz[0], blend_weight,
                         {(2*FRAME_W){1'b0}}};
          end else begin
            out_data <= {{(NUM_AXES*OUT_W){1'b0}}, blend_weight,
                         res_fb[FRAME_W-1:0], res_fa[FRAME_W-1:0]};
          end
        end
      end
      default: ;
    endcase
  end

  kvi_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  kvi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != ST_IDLE)
  `ASSERT_NEXT(a_done_loads_output, clk, rst, (state == ST_DONE) && out_free, m_axis_tvalid)
  `ASSERT_IMPLIES(a_divider_in_tick, clk, rst, div_stat.busy, div_phase)

endmodule
